/* sv/vn_pkg.sv */
package vn_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 31;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic [31:0]        vec_length;
    logic               zero_length;
  } vec_out_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
                                           input logic [31:0] len);
    logic [32:0] r2;
    logic        ge;
    logic [32:0] diff;
    r2   = {rem, nbit};
    ge   = (r2 >= {1'b0, len});
    diff = r2 - {1'b0, len};
    return {ge, (ge ? diff[31:0] : r2[31:0])};
  endfunction

  // one digit of the square root recurrence: returns {root bit, new remainder}
  function automatic logic [34:0] sqrt_step(input logic [33:0] rem, input logic [1:0] pair,
                                            input logic [31:0] root);
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] diff;
    r2    = {rem, pair};
    trial = {2'b00, root, 2'b01};
    ge    = (r2 >= trial);
    diff  = r2 - trial;
    return {ge, (ge ? diff[33:0] : r2[33:0])};
  endfunction

endpackage

/* sv/vn_div.sv */
module vn_div (
  input  logic        clk_i,
  input  logic        ce_i,
  input  logic [31:0] len_i,
  input  logic [31:0] mag_i,
  output logic [30:0] quo_o
);

  logic [31:0] r_q [vn_pkg::DivSteps];
  logic [29:0] d_q [vn_pkg::DivSteps];
  logic [30:0] q_q [vn_pkg::DivSteps];
  logic [31:0] l_q [vn_pkg::DivSteps];

  for (genvar j = 0; j < vn_pkg::DivSteps; j++) begin : g_step
    logic [31:0] rem_in;
    logic        bit_in;
    logic [29:0] d_in;
    logic [30:0] q_in;
    logic [31:0] len_in;
    logic [32:0] res;

    if (j == 0) begin : g_first
      // magnitude never exceeds the length, so half of it is a valid remainder
      assign rem_in = {1'b0, mag_i[31:1]};
      assign bit_in = mag_i[0];
      assign d_in   = '0;
      assign q_in   = '0;
      assign len_in = len_i;
    end else begin : g_next
      assign rem_in = r_q[j-1];
      assign bit_in = d_q[j-1][29];
      assign d_in   = {d_q[j-1][28:0], 1'b0};
      assign q_in   = q_q[j-1];
      assign len_in = l_q[j-1];
    end

    assign res = vn_pkg::div_step(rem_in, bit_in, len_in);

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        r_q[j] <= res[31:0];
        d_q[j] <= d_in;
        q_q[j] <= {q_in[29:0], res[32]};
        l_q[j] <= len_in;
      end
    end
  end

  assign quo_o = q_q[vn_pkg::DivSteps-1];

endmodule

/* sv/vector3_normalize_top.sv */
// Normalizes one 3D vector per word: signed Q16.16 in, the floor square root
// length (unsigned Q16.16) and each component over that length (signed Q2.30,
// truncated toward zero) out. A new word is taken every cycle unless the
// output stalls; a word passes through magnitude, square and sum registers,
// the 32-stage square root (one root bit per stage), the 31-stage divider
// (one quotient bit per stage) and the output register. An
// all-zero vector gives zero length, zero components and zero_length set.
// A stall on the output holds the whole pipeline.
module vector3_normalize_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vn_pkg::vec_in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vn_pkg::vec_out_t  out_data_o
);

  localparam int unsigned Latency = 3 + vn_pkg::SqrtSteps + vn_pkg::DivSteps + 1;

  logic ce;
  logic [Latency-1:0] v_q;

  assign ce          = !(v_q[Latency-1] && out_stall_i);
  assign in_stall_o  = !ce;
  assign out_valid_o = v_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ce) begin
      v_q <= {v_q[Latency-2:0], in_valid_i};
    end
  end

  // magnitudes and signs
  logic [31:0] mag_d [3];
  logic [2:0]  neg_d;
  logic [31:0] mag_q [3];
  logic [2:0]  neg_q;

  assign neg_d    = {in_data_i.vec_x[31], in_data_i.vec_y[31], in_data_i.vec_z[31]};
  assign mag_d[0] = neg_d[2] ? 32'(-in_data_i.vec_x) : 32'(in_data_i.vec_x);
  assign mag_d[1] = neg_d[1] ? 32'(-in_data_i.vec_y) : 32'(in_data_i.vec_y);
  assign mag_d[2] = neg_d[0] ? 32'(-in_data_i.vec_z) : 32'(in_data_i.vec_z);

  // squares
  logic [63:0] sqr_q [3];
  logic [31:0] mag2_q [3];
  logic [2:0]  neg2_q;

  // sum of squares enters the root pipeline at index 0
  logic [63:0] sn_q [vn_pkg::SqrtSteps+1];
  logic [33:0] sr_q [vn_pkg::SqrtSteps+1];
  logic [31:0] sq_q [vn_pkg::SqrtSteps+1];
  logic [31:0] sm_q [vn_pkg::SqrtSteps+1][3];
  logic [2:0]  sg_q [vn_pkg::SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= mag_d[i];
        sqr_q[i]  <= mag_q[i] * mag_q[i];
        mag2_q[i] <= mag_q[i];
        sm_q[0][i] <= mag2_q[i];
      end
      neg_q    <= neg_d;
      neg2_q   <= neg_q;
      sg_q[0]  <= neg2_q;
      sn_q[0]  <= sqr_q[0] + sqr_q[1] + sqr_q[2];
      sr_q[0]  <= '0;
      sq_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < vn_pkg::SqrtSteps; k++) begin : g_sqrt
    logic [34:0] res;
    assign res = vn_pkg::sqrt_step(sr_q[k], sn_q[k][63:62], sq_q[k]);
    always_ff @(posedge clk_i) begin
      if (ce) begin
        sn_q[k+1] <= {sn_q[k][61:0], 2'b00};
        sr_q[k+1] <= res[33:0];
        sq_q[k+1] <= {sq_q[k][30:0], res[34]};
        sm_q[k+1] <= sm_q[k];
        sg_q[k+1] <= sg_q[k];
      end
    end
  end

  logic [31:0] root;
  assign root = sq_q[vn_pkg::SqrtSteps];

  // three divider lanes, sideband runs alongside
  logic [30:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vn_div u_div (
      .clk_i (clk_i),
      .ce_i  (ce),
      .len_i (root),
      .mag_i (sm_q[vn_pkg::SqrtSteps][i]),
      .quo_o (quo[i])
    );
  end

  logic [31:0] dl_q [vn_pkg::DivSteps];
  logic [2:0]  dg_q [vn_pkg::DivSteps];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dl_q[0] <= root;
      dg_q[0] <= sg_q[vn_pkg::SqrtSteps];
      for (int j = 1; j < vn_pkg::DivSteps; j++) begin
        dl_q[j] <= dl_q[j-1];
        dg_q[j] <= dg_q[j-1];
      end
    end
  end

  logic [31:0] len_f;
  logic [2:0]  neg_f;
  logic        zero_f;
  logic [31:0] unit_d [3];

  assign len_f  = dl_q[vn_pkg::DivSteps-1];
  assign neg_f  = dg_q[vn_pkg::DivSteps-1];
  assign zero_f = (len_f == '0);

  for (genvar i = 0; i < 3; i++) begin : g_sign
    assign unit_d[i] = zero_f ? '0 :
                       (neg_f[2-i] ? 32'(-{1'b0, quo[i]}) : {1'b0, quo[i]});
  end

  vn_pkg::vec_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_q.unit_x      <= unit_d[0];
      out_q.unit_y      <= unit_d[1];
      out_q.unit_z      <= unit_d[2];
      out_q.vec_length  <= len_f;
      out_q.zero_length <= zero_f;
    end
  end

  assign out_data_o = out_q;

  a_zero_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |-> out_data_o.vec_length == '0)
    else $error("zero_length with nonzero length");

  a_len_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.zero_length |-> out_data_o.vec_length != '0)
    else $error("zero length not flagged");

  a_zero_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |->
      out_data_o.unit_x == '0 && out_data_o.unit_y == '0 && out_data_o.unit_z == '0)
    else $error("zero vector components not zero");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(out_data_o) && out_valid_o)
    else $error("output word changed under stall");

endmodule
